FILE: sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache LRU lookup.
package sacl_pkg;

    // Operation codes carried in the input word
    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_IDLE   = 2'd1,
        OP_INVAL  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_OFFSET_BITS = 1'b0,
        CFG_SET_BITS    = 1'b1
    } t_cfg_idx;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 2;
    localparam int OFF_W      = 5;
    localparam int SETB_W     = 3;
    localparam int FIELD_W    = 7;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 72;

endpackage

FILE: sv/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache tag lookup with age-rank LRU replacement.
//
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word. The first-stage registers and the result
// register load only when the pipe advances; a stalled result holds the whole
// pipe and the input. The first stage computes the set index and tag and
// reads the set's row (all ways' tags, valid bits and ages) from the tag
// memory, which has one read and one write port; the second stage compares the
// ways, picks the hit or victim way, writes the updated row back and loads the
// result register. A word that reads the set being written in the same cycle
// gets the new row forwarded. Invalidate clears every valid bit through
// per-set flags, so there is no clearing pass after reset.
// Configure offset_bits and set_bits only while no word is in flight.
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int WAYS      = 4,
    parameter int SETS      = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // operation[1:0], address[33:2], zero pad
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // hit[0], way_used[2:1],
                                                 // miss_total[34:3],
                                                 // reference_total[66:35], zero pad
);

    localparam int AW   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TW   = AW;
    localparam int AGEW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW   = WAYS * (TW + 1 + AGEW);

    function automatic logic [WAYS*AGEW-1:0] reset_ages();
        logic [WAYS*AGEW-1:0] a;
        a = '0;
        for (int i = 0; i < WAYS; i++) begin
            a[i*AGEW +: AGEW] = AGEW'(i);
        end
        return a;
    endfunction

    localparam logic [WAYS*AGEW-1:0] AGE_RST = reset_ages();

    // reduce the extracted index modulo SETS by compare and subtract
    function automatic logic [SW-1:0] set_mod(input logic [FIELD_W-1:0] f);
        logic [17:0] r;
        r = 18'(f);
        for (int k = FIELD_W - 1; k >= 0; k--) begin
            if (r >= (18'(SETS) << k)) begin
                r = r - (18'(SETS) << k);
            end
        end
        return r[SW-1:0];
    endfunction

    // configuration
    logic [OFF_W-1:0]  r_offset_bits;
    logic [SETB_W-1:0] r_set_bits;

    // first stage
    logic              r_v1;
    logic [OP_W-1:0]   r_op1;
    logic [SW-1:0]     r_set1;
    logic [TW-1:0]     r_tag1;
    logic [RW-1:0]     r_rd_row;
    logic              r_fwd;
    logic [RW-1:0]     r_fwd_row;

    // result register and counters
    logic                 r_ov;
    logic                 r_hit_o;
    logic [WAY_OUT_W-1:0] r_way_o;
    logic [CNT_W-1:0]     r_miss;
    logic [CNT_W-1:0]     r_ref;

    // per-set flags: row written since reset, row valid bits live since invalidate
    logic [SETS-1:0] r_written;
    logic [SETS-1:0] r_live;

    logic [RW-1:0] r_mem [SETS];

    logic                 advance;
    logic [OP_W-1:0]      op_in;
    logic [ADDR_W-1:0]    addr_m;
    logic [ADDR_W-1:0]    addr_off;
    logic [FIELD_W-1:0]   field;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_W-1:0]    addr_tag;
    logic [SW-1:0]        set_n;
    logic [TW-1:0]        tag_n;

    logic [RW-1:0]        cur_row;
    logic [WAYS*TW-1:0]   cur_tags;
    logic [WAYS-1:0]      cur_valids;
    logic [WAYS*AGEW-1:0] cur_ages;
    logic [WAYS*TW-1:0]   new_tags;
    logic [WAYS-1:0]      new_valids;
    logic [WAYS*AGEW-1:0] new_ages;
    logic [RW-1:0]        new_row;
    logic                 lk_hit;
    logic [WW-1:0]        lk_way;
    logic [WW+1:0]        way_ext;
    logic                 s1_wr;
    logic                 s1_inval;
    logic [CNT_W-1:0]     n_miss;
    logic [CNT_W-1:0]     n_ref;

    assign advance       = !r_ov || m_axis_tready;
    assign s_axis_tready = advance;
    assign o_cfg_ready   = 1'b1;

    // address split
    assign op_in     = s_axis_tdata[OP_W-1:0];
    assign addr_m    = ADDR_W'(s_axis_tdata[OP_W +: AW]);
    assign addr_off  = addr_m >> r_offset_bits;
    assign field     = addr_off[FIELD_W-1:0] & ((FIELD_W'(1) << r_set_bits) - FIELD_W'(1));
    assign set_n     = set_mod(field);
    assign tag_shift = SHIFT_W'(r_offset_bits) + SHIFT_W'(r_set_bits);
    assign addr_tag  = addr_m >> tag_shift;
    assign tag_n     = addr_tag[TW-1:0];

    // row seen by the second stage
    assign cur_row = r_fwd ? r_fwd_row : r_rd_row;

    always_comb begin
        cur_tags   = cur_row[WAYS*TW-1:0];
        cur_valids = cur_row[WAYS*TW +: WAYS];
        cur_ages   = cur_row[WAYS*(TW+1) +: WAYS*AGEW];
        if (!r_fwd) begin
            if (!r_written[r_set1]) begin
                cur_tags = '0;
                cur_ages = AGE_RST;
            end
            if (!r_live[r_set1]) begin
                cur_valids = '0;
            end
        end
    end

    sacl_lru_way #(
        .WAYS (WAYS),
        .TW   (TW),
        .AGEW (AGEW),
        .WW   (WW)
    ) u_lru_way (
        .i_tags   (cur_tags),
        .i_valids (cur_valids),
        .i_ages   (cur_ages),
        .i_tag    (r_tag1),
        .o_hit    (lk_hit),
        .o_way    (lk_way),
        .o_tags   (new_tags),
        .o_valids (new_valids),
        .o_ages   (new_ages)
    );

    assign new_row  = {new_ages, new_valids, new_tags};
    assign way_ext  = {2'b00, lk_way};
    assign s1_wr    = r_v1 && (r_op1 == OP_ACCESS);
    assign s1_inval = r_v1 && (r_op1 == OP_INVAL);
    assign n_miss   = (s1_wr && !lk_hit && (r_miss != '1)) ? r_miss + CNT_W'(1) : r_miss;
    assign n_ref    = (r_ref != '1) ? r_ref + CNT_W'(1) : r_ref;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= '0;
            r_set_bits    <= '0;
            r_v1          <= 1'b0;
            r_fwd         <= 1'b0;
            r_ov          <= 1'b0;
            r_miss        <= '0;
            r_ref         <= '0;
            r_written     <= '0;
            r_live        <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFF_W-1:0];
                    CFG_SET_BITS:    r_set_bits    <= i_cfg_data[SETB_W-1:0];
                    default:         r_set_bits    <= r_set_bits;
                endcase
            end
            if (advance) begin
                r_v1  <= s_axis_tvalid;
                // forward the row being written to a word reading the same set
                r_fwd <= s_axis_tvalid && s1_wr && (set_n == r_set1);
                r_ov  <= r_v1;
                if (r_v1) begin
                    r_miss <= n_miss;
                    r_ref  <= n_ref;
                end
                if (s1_wr) begin
                    r_written[r_set1] <= 1'b1;
                    r_live[r_set1]    <= 1'b1;
                end
                if (s1_inval) begin
                    r_live <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_op1     <= op_in;
            r_set1    <= set_n;
            r_tag1    <= tag_n;
            r_fwd_row <= new_row;
            r_hit_o   <= s1_wr && lk_hit;
            r_way_o   <= s1_wr ? way_ext[WAY_OUT_W-1:0] : '0;
        end
    end

    // tag memory: one row per set
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (s1_wr) begin
                r_mem[r_set1] <= new_row;
            end
            r_rd_row <= r_mem[set_n];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {(OUT_W - 1 - WAY_OUT_W - 2*CNT_W)'(0), r_ref, r_miss, r_way_o, r_hit_o};

    // forwarding only follows a word that really entered the pipe
    a_fwd_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v1)
        else $error("forward flag set without a word in the first stage");

    a_miss_le_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= r_ref)
        else $error("miss count exceeds reference count");

    a_hit_keeps_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && s1_wr && lk_hit) |=> (r_miss == $past(r_miss)))
        else $error("miss count moved on a hit");

    a_inval_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && s1_inval) |=> (r_live == '0))
        else $error("invalidate left a set live");

endmodule

FILE: sv/sacl_lru_way.sv
// Way selection for one set: first tag match, hit check, LRU victim and age update.
module sacl_lru_way #(
    parameter int WAYS = 4,
    parameter int TW   = 32,
    parameter int AGEW = 2,
    parameter int WW   = 2
) (
    input  logic [WAYS*TW-1:0]   i_tags,
    input  logic [WAYS-1:0]      i_valids,
    input  logic [WAYS*AGEW-1:0] i_ages,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_hit,
    output logic [WW-1:0]        o_way,
    output logic [WAYS*TW-1:0]   o_tags,
    output logic [WAYS-1:0]      o_valids,
    output logic [WAYS*AGEW-1:0] o_ages
);

    logic            found;
    logic [WW-1:0]   way;
    logic [AGEW-1:0] old_age;

    always_comb begin
        found = 1'b0;
        way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found && (i_tags[i*TW +: TW] == i_tag)) begin
                found = 1'b1;
                way   = WW'(i);
            end
        end
        // no tag match: take the last way holding the oldest age
        if (!found) begin
            for (int i = 0; i < WAYS; i++) begin
                if (i_ages[i*AGEW +: AGEW] == AGEW'(WAYS - 1)) begin
                    way = WW'(i);
                end
            end
        end
    end

    assign o_hit   = found && i_valids[way];
    assign o_way   = way;
    assign old_age = i_ages[way*AGEW +: AGEW];

    always_comb begin
        o_tags   = i_tags;
        o_valids = i_valids;
        o_ages   = i_ages;
        for (int i = 0; i < WAYS; i++) begin
            if (i_ages[i*AGEW +: AGEW] < old_age) begin
                o_ages[i*AGEW +: AGEW] = i_ages[i*AGEW +: AGEW] + AGEW'(1);
            end
        end
        o_ages[way*AGEW +: AGEW] = '0;
        if (!o_hit) begin
            o_tags[way*TW +: TW] = i_tag;
            o_valids[way]        = 1'b1;
        end
    end

endmodule

FILE: bench/tb_set_assoc_cache_lru_lookup.sv
// Self-checking bench for the cache tag lookup: directed table, then random traffic under stalls.
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru_lookup;
    import sacl_pkg::*;

    localparam int NUM_WAYS    = 4;
    localparam int NUM_SETS    = 16;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 11;
    localparam int PHASE_WORDS = 137;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // receiver stall patterns
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;
    localparam int READY_PERIOD = 3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way;
        logic [31:0] misses;
        logic [31:0] refs;
    } t_lookup_result;

    typedef struct {
        t_row_kind      kind;
        t_cfg_idx       cfg_idx;
        logic [1:0]     op;
        logic [31:0]    value;
        bit             known;
        t_lookup_result want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // operation[1:0], address[33:2], zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // hit[0], way_used[2:1], miss_total[34:3],
                                                // reference_total[66:35], zero pad

    // predictor state
    logic [31:0] tag_mem   [NUM_SETS][NUM_WAYS];
    logic        valid_mem [NUM_SETS][NUM_WAYS];
    logic [1:0]  age_mem   [NUM_SETS][NUM_WAYS];
    logic [31:0] miss_cnt;
    logic [31:0] ref_cnt;
    logic [4:0]  cfg_offset;
    logic [2:0]  cfg_setbits;

    t_lookup_result expected_results[$];
    t_dir_row       dir_rows[$];

    int fail_count    = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int inval_sent    = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;
    int stall_mode    = READY_ALWAYS;
    int stall_left    = 0;
    int stall_phase   = 0;

    set_assoc_cache_lru_lookup u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $realtime,
                     expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Output side stalls: switch pattern every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(READY_PERIOD, READY_ALWAYS);
            stall_left = $urandom_range(200, 20);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(1, 0));
            READY_SPARSE: m_axis_tready <= ($urandom_range(3, 0) == 0);
            default:      m_axis_tready <= (stall_phase % 5) < 3;
        endcase
    end

    function automatic t_lookup_result predict_lookup(input logic [1:0] op,
                                                      input logic [31:0] addr);
        t_lookup_result res;
        logic [63:0]    wide;
        logic [31:0]    tag;
        logic [3:0]     set_idx;
        logic [1:0]     old_age;
        int             shift;
        int             way;
        bit             found;
        res = '0;
        if (op == OP_ACCESS) begin
            wide    = {32'b0, addr};
            shift   = int'(cfg_offset) + int'(cfg_setbits);
            tag     = 32'(wide >> shift);
            set_idx = 4'((wide >> cfg_offset) & ((64'd1 << cfg_setbits) - 64'd1));
            found   = 1'b0;
            way     = 0;
            for (int i = 0; i < NUM_WAYS; i++) begin
                if (!found && tag_mem[set_idx][i] == tag) begin
                    way   = i;
                    found = 1'b1;
                end
            end
            if (found && valid_mem[set_idx][way]) begin
                res.hit = 1'b1;
            end else begin
                // no tag match: evict the oldest way
                if (!found) begin
                    way = 0;
                    for (int i = 0; i < NUM_WAYS; i++)
                        if (age_mem[set_idx][i] == 2'(NUM_WAYS - 1)) way = i;
                end
                tag_mem[set_idx][way]   = tag;
                valid_mem[set_idx][way] = 1'b1;
                if (miss_cnt != '1) miss_cnt++;
            end
            old_age = age_mem[set_idx][way];
            for (int i = 0; i < NUM_WAYS; i++)
                if (age_mem[set_idx][i] < old_age) age_mem[set_idx][i]++;
            age_mem[set_idx][way] = '0;
            res.way = 2'(way);
        end else if (op == OP_INVAL) begin
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < NUM_WAYS; w++) valid_mem[s][w] = 1'b0;
        end
        if (ref_cnt != '1) ref_cnt++;
        res.misses = miss_cnt;
        res.refs   = ref_cnt;
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        t_lookup_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit    = m_axis_tdata[0];
            got.way    = m_axis_tdata[2:1];
            got.misses = m_axis_tdata[34:3];
            got.refs   = m_axis_tdata[66:35];
            results_seen++;
            if (got.hit) hits_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected: %h", $realtime, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit expected %0h got %0h", $realtime, want.hit, got.hit);
                    fail_count++;
                end
                if (got.way !== want.way) begin
                    $display("%0t: way_used expected %0d got %0d", $realtime, want.way,
                             got.way);
                    fail_count++;
                end
                if (got.misses !== want.misses) begin
                    $display("%0t: miss_total expected %0d got %0d", $realtime,
                             want.misses, got.misses);
                    fail_count++;
                end
                if (got.refs !== want.refs) begin
                    $display("%0t: reference_total expected %0d got %0d", $realtime,
                             want.refs, got.refs);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [31:0] addr, input bit known,
                             input t_lookup_result typed_want);
        t_lookup_result predicted;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, addr, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_lookup(op, addr);
        expected_results.push_back(known ? typed_want : predicted);
        words_sent++;
        if (op == OP_INVAL) inval_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [4:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_OFFSET_BITS) cfg_offset = value;
        else cfg_setbits = value[2:0];
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [4:0] value);
        dir_rows.push_back('{ROW_CFG, idx, OP_IDLE, {27'b0, value}, 1'b0, '0});
    endtask

    task automatic add_item(input logic [1:0] op, input logic [31:0] addr);
        dir_rows.push_back('{ROW_ITEM, CFG_OFFSET_BITS, op, addr, 1'b0, '0});
    endtask

    task automatic add_known(input logic [1:0] op, input logic [31:0] addr, input logic hit,
                             input logic [1:0] way, input int misses, input int refs);
        dir_rows.push_back('{ROW_ITEM, CFG_OFFSET_BITS, op, addr, 1'b1,
                             '{hit, way, 32'(misses), 32'(refs)}});
    endtask

    initial begin
        int          offsets  [PHASES] = '{0, 31, 4, 2, 6, 0, 5, 3, 31, 1, 2};
        int          setbits  [PHASES] = '{0, 7, 4, 2, 3, 4, 5, 1, 0, 7, 6};
        logic [31:0] pool     [16];
        logic [31:0] offmask;
        logic [31:0] addr;
        logic [1:0]  op;
        int          pool_size;
        int          burst_left;
        int          pick;

        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                tag_mem[s][w]   = '0;
                valid_mem[s][w] = 1'b0;
                age_mem[s][w]   = 2'(w);
            end
        end
        miss_cnt    = '0;
        ref_cnt     = '0;
        cfg_offset  = '0;
        cfg_setbits = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single set, tag is the whole address: walk fill, hit, idle, evict, invalidate
        add_cfg(CFG_OFFSET_BITS, 5'd0);
        add_cfg(CFG_SET_BITS, 5'd0);
        add_known(OP_ACCESS, 32'h0000_0000, 1'b0, 2'd0, 1, 1);
        add_known(OP_ACCESS, 32'h0000_0000, 1'b1, 2'd0, 1, 2);
        add_known(OP_IDLE,   32'h0000_0000, 1'b0, 2'd0, 1, 3);
        add_known(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 2'd0, 1, 4);
        add_known(OP_ACCESS, 32'hFFFF_FFFF, 1'b0, 2'd3, 2, 5);
        add_known(OP_ACCESS, 32'hFFFF_FFFF, 1'b1, 2'd3, 2, 6);
        add_known(OP_INVAL,  32'h0000_0000, 1'b0, 2'd0, 2, 7);
        add_known(OP_ACCESS, 32'hFFFF_FFFF, 1'b0, 2'd3, 3, 8);
        add_known(OP_ACCESS, 32'h0000_0000, 1'b0, 2'd0, 4, 9);
        add_known(OP_ACCESS, 32'h1234_5678, 1'b0, 2'd2, 5, 10);
        add_known(OP_ACCESS, 32'h8000_0000, 1'b0, 2'd1, 6, 11);
        add_known(OP_ACCESS, 32'h1234_5678, 1'b1, 2'd2, 6, 12);
        add_known(OP_ACCESS, 32'hAAAA_AAAA, 1'b0, 2'd3, 7, 13);
        add_item(OP_ACCESS, 32'h5555_5555);
        add_item(OP_ACCESS, 32'h0000_0001);
        // widest offset and set field: shift past the address
        add_cfg(CFG_OFFSET_BITS, 5'd31);
        add_cfg(CFG_SET_BITS, 5'b11111);
        add_item(OP_ACCESS, 32'hFFFF_FFFF);
        add_item(OP_ACCESS, 32'h7FFF_FFFF);
        add_cfg(CFG_OFFSET_BITS, 5'd4);
        add_cfg(CFG_SET_BITS, 5'd4);
        add_item(OP_ACCESS, 32'h0000_00F0);
        add_item(OP_ACCESS, 32'hFFFF_FF0F);
        add_item(OP_INVAL, 32'hFFFF_FFFF);
        add_item(OP_IDLE, 32'h0000_00F0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].value[4:0]);
            end else begin
                send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].known,
                          dir_rows[i].want);
                if ($urandom_range(2, 0) == 0) hold_off($urandom_range(3, 1));
            end
        end

        // Random phases: a small working set per phase so hits and evictions both occur
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_OFFSET_BITS, 5'(offsets[ph]));
            write_reg(CFG_SET_BITS, 5'(setbits[ph]));
            offmask   = (cfg_offset == 0) ? '0 : (32'hFFFF_FFFF >> (32 - cfg_offset));
            pool_size = $urandom_range(12, 2);
            for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
            burst_left = $urandom_range(24, 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 86) op = OP_ACCESS;
                else if (pick < 92) op = OP_IDLE;
                else if (pick < 95) op = OP_UNUSED;
                else op = OP_INVAL;
                if ($urandom_range(99, 0) < 78)
                    addr = (pool[$urandom_range(pool_size - 1, 0)] & ~offmask)
                           | ($urandom & offmask);
                else
                    addr = $urandom;
                send_word(op, addr, 1'b0, '0);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 1);
                    if ($urandom_range(3, 0) != 0) hold_off($urandom_range(6, 1));
                end else begin
                    burst_left--;
                end
                // drain everything once in a while mid-phase
                if ($urandom_range(199, 0) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d words (%0d invalidates) over %0d register writes;",
                 words_sent, inval_sent, cfg_writes);
        $display("checked %0d results, %0d hits, %0d failures.",
                 results_seen, hits_seen, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
